FILE: design/sfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, codes and the frame successor function for the sprite frame
// sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // transaction function codes
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_LOAD    = 3'd1;
  localparam logic [2:0] FUNC_SET     = 3'd2;
  localparam logic [2:0] FUNC_RESTART = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [1:0] REG_LOOP_ENABLE = 2'd0;
  localparam logic [1:0] REG_FIRST_FRAME = 2'd1;
  localparam logic [1:0] REG_END_FRAME   = 2'd2;
  localparam logic [1:0] REG_SPEED       = 2'd3;

  // register reset values
  localparam logic [8:0]  END_FRAME_RST = 9'd1;
  localparam logic [15:0] SPEED_RST     = 16'd256;

  // frame numbers are 8 bits wide
  localparam int unsigned FRAME_NUMS = 256;

  // steps before whole frame cycles are removed at once
  localparam int unsigned STEP_LIMIT = 512;
  localparam int unsigned STEP_W     = 9;

  typedef struct packed {
    logic       busy;
    logic       done;
  } sfs_rem_status_t;

  typedef struct packed {
    logic [7:0] frame;
    logic       hold;
  } sfs_step_t;

  function automatic sfs_step_t sfs_next(
    input logic [7:0] f,
    input logic [8:0] end_frame,
    input logic       loop_enable,
    input logic [7:0] first_frame
  );
    sfs_step_t  r;
    logic [8:0] n;
    logic [8:0] last;
    n    = {1'b0, f} + 9'd1;
    last = end_frame - 9'd1;
    r.hold  = 1'b0;
    r.frame = n[7:0];
    if (n == end_frame) begin
      if (loop_enable) begin
        r.frame = first_frame;
      end else begin
        r.frame = last[7:0];
        r.hold  = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/sfs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/sfs_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_rem
// Iterative restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfs_rem (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [31:0]              dividend,
  input  wire logic [31:0]              divisor,
  output sfs_pkg::sfs_rem_status_t      status,
  output logic      [31:0]              rem
);

  logic [31:0] shreg;
  logic [5:0]  cnt;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, shreg[31]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= status.busy && !start && (cnt == 6'd1);
      if (start) begin
        rem         <= '0;
        shreg       <= dividend;
        cnt         <= 6'd32;
        status.busy <= 1'b1;
      end else if (status.busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= diff[31:0];
        end else begin
          rem <= trial[31:0];
        end
        shreg <= {shreg[30:0], 1'b0};
        cnt   <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          status.busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/sprite_frame_sequencer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit
// Sprite animation timer: scaled tick time is added to a saturating Q24.8
// accumulator, which a sequencer walks through the frame duration table.
// ----------------------------------------------------------------------------
//   channel  handshake                 payload
//   in       in_valid / in_ready       func, elapsed_ms, frame_index, duration_ms
//   out      out_valid / out_ready     current_frame, finished, time_in_frame
//   cfg      psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// non-tick transactions: go straight to the result stage, next accept once it is registered
// tick: S_MUL, S_ADD, then S_RD and S_CMP per frame step (one table read each);
//   after 512 steps a cycle sum pass runs S_CYC_RD and S_CYC_ACC per frame of the cycle,
//   then S_DIV_GO, and S_DIV_WAIT when the remainder unit runs
// in_ready is high only while idle; a waiting result does not block accept,
//   the next result waits until the output register is free
// synchronous active-high reset; duration table is not cleared
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit #(
  parameter int unsigned FRAME_COUNT = 256,
  localparam int unsigned AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    func,
  input  wire logic [15:0]                   elapsed_ms,
  input  wire logic [7:0]                    frame_index,
  input  wire logic [15:0]                   duration_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [7:0]                    current_frame,
  output logic                               finished,
  output logic      [15:0]                   time_in_frame,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfs_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_RD, S_CMP, S_CYC_RD, S_CYC_ACC, S_DIV_GO, S_DIV_WAIT, S_DONE
  } state_t;

  state_t      state;
  logic        loop_enable;
  logic [7:0]  first_frame;
  logic [8:0]  end_frame;
  logic [15:0] speed;

  logic [7:0]  frame;
  logic [31:0] acc;
  logic        done_flag;
  logic [15:0] ms_q;
  logic [31:0] prod;
  logic [sfs_pkg::STEP_W-1:0] steps;
  logic        reduced;
  logic [7:0]  cyc_frame;
  logic [31:0] cyc_sum;

  logic        accept;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [AW-1:0] idx_tab [sfs_pkg::FRAME_NUMS];
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [15:0] ram_rdata;
  logic [15:0] dur_eff;
  logic [23:0] dur_q8;
  logic        acc_gt;
  logic [32:0] sum_sat;
  logic        rem_start;
  sfs_pkg::sfs_rem_status_t rem_status;
  logic [31:0] rem_val;
  sfs_pkg::sfs_step_t nx_frame;
  sfs_pkg::sfs_step_t nx_cyc;

  // frame number to table index
  for (genvar g = 0; g < sfs_pkg::FRAME_NUMS; g++) begin : g_idx
    localparam int unsigned IDX = g % FRAME_COUNT;
    assign idx_tab[g] = AW'(IDX);
  end

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[3:2];

  assign ram_we    = accept && (func == sfs_pkg::FUNC_LOAD);
  assign ram_waddr = idx_tab[frame_index];
  assign ram_raddr = (state == S_CYC_RD) ? idx_tab[cyc_frame] : idx_tab[frame];

  assign dur_eff   = (ram_rdata == 16'd0) ? 16'd1 : ram_rdata;
  assign dur_q8    = {dur_eff, 8'h00};
  assign acc_gt    = acc > {8'd0, dur_q8};
  assign sum_sat   = {1'b0, acc} + {1'b0, prod};
  assign rem_start = (state == S_DIV_GO) && (acc > cyc_sum);

  assign nx_frame  = sfs_pkg::sfs_next(frame, end_frame, loop_enable, first_frame);
  assign nx_cyc    = sfs_pkg::sfs_next(cyc_frame, end_frame, loop_enable, first_frame);

  always_comb begin
    case (cfg_idx)
      sfs_pkg::REG_LOOP_ENABLE: prdata = {31'd0, loop_enable};
      sfs_pkg::REG_FIRST_FRAME: prdata = {24'd0, first_frame};
      sfs_pkg::REG_END_FRAME:   prdata = {23'd0, end_frame};
      sfs_pkg::REG_SPEED:       prdata = {16'd0, speed};
      default:                  prdata = '0;
    endcase
  end

  sfs_ram #(
    .WIDTH (16),
    .DEPTH (FRAME_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (duration_ms),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sfs_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (acc - 32'd1),
    .divisor  (cyc_sum),
    .status   (rem_status),
    .rem      (rem_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable <= 1'b0;
      first_frame <= '0;
      end_frame   <= sfs_pkg::END_FRAME_RST;
      speed       <= sfs_pkg::SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        sfs_pkg::REG_LOOP_ENABLE: loop_enable <= pwdata[0];
        sfs_pkg::REG_FIRST_FRAME: first_frame <= pwdata[7:0];
        sfs_pkg::REG_END_FRAME:   end_frame   <= pwdata[8:0];
        sfs_pkg::REG_SPEED:       speed       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      frame     <= '0;
      acc       <= '0;
      done_flag <= 1'b0;
      out_valid <= 1'b0;
      steps     <= '0;
      reduced   <= 1'b0;
    end else begin
      if (out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (func == sfs_pkg::FUNC_TICK) ? S_MUL : S_DONE;
            case (func)
              sfs_pkg::FUNC_TICK: begin
                ms_q <= elapsed_ms;
              end
              sfs_pkg::FUNC_SET: begin
                frame     <= frame_index;
                done_flag <= 1'b0;
              end
              sfs_pkg::FUNC_RESTART: begin
                frame     <= first_frame;
                acc       <= '0;
                done_flag <= 1'b0;
              end
              sfs_pkg::FUNC_CLEAR: begin
                acc <= '0;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod  <= {16'd0, ms_q} * {16'd0, speed};
          state <= S_ADD;
        end
        S_ADD: begin
          acc     <= sum_sat[32] ? 32'hFFFF_FFFF : sum_sat[31:0];
          steps   <= '0;
          reduced <= 1'b0;
          state   <= S_RD;
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (acc_gt) begin
            acc   <= acc - {8'd0, dur_q8};
            frame <= nx_frame.frame;
            if (nx_frame.hold) begin
              done_flag <= 1'b1;
            end
            steps <= steps + 1'b1;
            if (!reduced && (steps == sfs_pkg::STEP_W'(sfs_pkg::STEP_LIMIT - 1))) begin
              cyc_frame <= nx_frame.frame;
              cyc_sum   <= '0;
              state     <= S_CYC_RD;
            end else begin
              state <= S_RD;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_CYC_RD: begin
          state <= S_CYC_ACC;
        end
        S_CYC_ACC: begin
          cyc_sum   <= cyc_sum + {8'd0, dur_q8};
          cyc_frame <= nx_cyc.frame;
          if (nx_cyc.frame == frame) begin
            state <= S_DIV_GO;
          end else begin
            state <= S_CYC_RD;
          end
        end
        S_DIV_GO: begin
          reduced <= 1'b1;
          if (rem_start) begin
            state <= S_DIV_WAIT;
          end else begin
            state <= S_RD;
          end
        end
        S_DIV_WAIT: begin
          if (rem_status.done) begin
            acc   <= rem_val + 32'd1;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            current_frame <= frame;
            finished      <= done_flag;
            time_in_frame <= (|acc[31:24]) ? 16'hFFFF : acc[23:8];
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("in_ready high right after accept");

  // state holds while idle without a transaction
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && !accept |=> $stable(acc) && $stable(frame) && $stable(done_flag))
    else $error("animation state changed while idle");

  // a new result only comes from the result stage
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside result stage");

  // remainder stays below the cycle sum
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_WAIT) && rem_status.done |-> rem_val < cyc_sum)
    else $error("remainder not below cycle sum");

endmodule
`default_nettype wire

FILE: verif/frame_sequence_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_sequence_checker
// Follows the configuration writes and every accepted input transaction,
// advances its own copy of the animation state and compares each result
// transaction with the oldest predicted frame status.
// ----------------------------------------------------------------------------
module frame_sequence_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [2:0]                     func,
  input  wire logic [15:0]                    elapsed_ms,
  input  wire logic [7:0]                     frame_index,
  input  wire logic [15:0]                    duration_ms,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [7:0]                     current_frame,
  input  wire logic                           finished,
  input  wire logic [15:0]                    time_in_frame,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic                           pready,
  input  wire logic [sfs_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output int                                  fail_count,
  output int                                  in_flight
);

  localparam int unsigned FOLD_AFTER = 512;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  frame;
    logic        fin;
    logic [15:0] tif;
  } frame_status_t;

  logic [15:0]   dur_tab [0:255];
  logic [7:0]    shown_frame;
  logic [31:0]   accum_q8;
  logic          done_q;
  logic          loop_en;
  logic [7:0]    first_f;
  logic [8:0]    end_f;
  logic [15:0]   speed_q8;
  frame_status_t pending_status_q [$];
  int            errs;
  int            accepted_cnt;
  int            matched_cnt;

  assign fail_count = errs;
  assign in_flight  = accepted_cnt - matched_cnt;

  function automatic logic [63:0] frame_len_q8(input logic [7:0] f);
    logic [15:0] d;
    d = dur_tab[f];
    if (d == 16'd0) d = 16'd1;
    return {40'd0, d, 8'd0};
  endfunction

  function automatic logic [7:0] following_frame(input logic [7:0] f, output logic held);
    logic [8:0] n;
    logic [8:0] last;
    n    = {1'b0, f} + 9'd1;
    last = end_f - 9'd1;
    held = 1'b0;
    if (n == end_f) begin
      if (loop_en) return first_f;
      held = 1'b1;
      return last[7:0];
    end
    return n[7:0];
  endfunction

  task automatic walk_frames();
    logic [63:0] rem;
    logic [63:0] cyc;
    logic [7:0]  f;
    logic        held;
    int unsigned steps;
    bit          folded;
    int          k;
    rem    = {32'd0, accum_q8};
    steps  = 0;
    folded = 1'b0;
    while (rem > frame_len_q8(shown_frame)) begin
      rem = rem - frame_len_q8(shown_frame);
      shown_frame = following_frame(shown_frame, held);
      if (held) done_q = 1'b1;
      steps++;
      // past this many steps the walk is inside a frame cycle
      if (!folded && steps >= FOLD_AFTER) begin
        f   = shown_frame;
        cyc = 64'd0;
        for (k = 0; k < FOLD_AFTER; k++) begin
          cyc = cyc + frame_len_q8(f);
          f = following_frame(f, held);
          if (f == shown_frame) break;
        end
        if (rem > cyc) rem = ((rem - 64'd1) % cyc) + 64'd1;
        folded = 1'b1;
      end
    end
    accum_q8 = rem[31:0];
  endtask

  task automatic advance_animation(output frame_status_t st);
    logic [63:0] sum;
    logic [23:0] whole;
    case (func)
      sfs_pkg::FUNC_TICK: begin
        sum = {32'd0, accum_q8} + {48'd0, elapsed_ms} * {48'd0, speed_q8};
        accum_q8 = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        walk_frames();
      end
      sfs_pkg::FUNC_LOAD: dur_tab[frame_index] = duration_ms;
      sfs_pkg::FUNC_SET: begin
        shown_frame = frame_index;
        done_q      = 1'b0;
      end
      sfs_pkg::FUNC_RESTART: begin
        shown_frame = first_f;
        accum_q8    = 32'd0;
        done_q      = 1'b0;
      end
      sfs_pkg::FUNC_CLEAR: accum_q8 = 32'd0;
      default: ;
    endcase
    whole    = accum_q8[31:8];
    st.frame = shown_frame;
    st.fin   = done_q;
    st.tif   = (whole > 24'h00FFFF) ? 16'hFFFF : whole[15:0];
  endtask

  initial begin
    errs         = 0;
    accepted_cnt = 0;
    matched_cnt  = 0;
  end

  always @(posedge clk) begin
    frame_status_t st;
    frame_status_t want;
    if (rst) begin
      shown_frame  = 8'd0;
      accum_q8     = 32'd0;
      done_q       = 1'b0;
      loop_en      = 1'b0;
      first_f      = 8'd0;
      end_f        = sfs_pkg::END_FRAME_RST;
      speed_q8     = sfs_pkg::SPEED_RST;
      pending_status_q.delete();
      accepted_cnt <= 0;
      matched_cnt  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[sfs_pkg::CFG_ADDR_W-1:2])
          sfs_pkg::REG_LOOP_ENABLE: loop_en  = pwdata[0];
          sfs_pkg::REG_FIRST_FRAME: first_f  = pwdata[7:0];
          sfs_pkg::REG_END_FRAME:   end_f    = pwdata[8:0];
          sfs_pkg::REG_SPEED:       speed_q8 = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_status_q.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("%0t: unexpected result frame %0d finished %0d time %0d", $realtime,
                     current_frame, finished, time_in_frame);
        end else begin
          want = pending_status_q.pop_front();
          if (want.frame !== current_frame || want.fin !== finished ||
              want.tif !== time_in_frame) begin
            errs++;
            if (errs <= MAX_REPORTS)
              $display({"%0t: status error: expected frame %0d finished %0d time %0d,",
                        " got %0d %0d %0d"},
                       $realtime, want.frame, want.fin, want.tif,
                       current_frame, finished, time_in_frame);
          end
          matched_cnt <= matched_cnt + 1;
        end
      end
      if (in_valid && in_ready) begin
        advance_animation(st);
        pending_status_q.push_back(st);
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Fills the frame duration table, runs directed and random transactions over
// several animation settings with random idling on both channels and one
// long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] FUNC_SPARE_A = 3'd5;
  localparam logic [2:0] FUNC_SPARE_B = 3'd6;
  localparam logic [2:0] FUNC_SPARE_C = 3'd7;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASES           = 9;
  localparam int PHASE_ITEMS      = 20;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic [2:0]                     func        = sfs_pkg::FUNC_TICK;
  logic [15:0]                    elapsed_ms  = 16'd0;
  logic [7:0]                     frame_index = 8'd0;
  logic [15:0]                    duration_ms = 16'd0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic [7:0]                     current_frame;
  logic                           finished;
  logic [15:0]                    time_in_frame;
  logic                           psel        = 1'b0;
  logic                           penable     = 1'b0;
  logic                           pwrite      = 1'b0;
  logic [sfs_pkg::CFG_ADDR_W-1:0] paddr       = '0;
  logic [31:0]                    pwdata      = 32'd0;
  logic [31:0]                    prdata;
  logic                           pready;

  int fail_count;
  int in_flight;
  int tx_idle_pct     = 23;
  int rx_idle_pct     = 45;
  bit long_hold_req   = 1'b0;

  sprite_frame_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .elapsed_ms(elapsed_ms), .frame_index(frame_index),
    .duration_ms(duration_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .current_frame(current_frame), .finished(finished), .time_in_frame(time_in_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  frame_sequence_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .elapsed_ms(elapsed_ms), .frame_index(frame_index),
    .duration_ms(duration_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .current_frame(current_frame), .finished(finished), .time_in_frame(time_in_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .in_flight(in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("sprite_frame_sequencer_unit: mismatch");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin : rx_side
    int k;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        for (k = 0; k < LONG_HOLD_CYCLES; k++) @(posedge clk);
        long_hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic l, input logic [7:0] f, input logic [8:0] e,
                               input logic [15:0] s);
    cfg_write(sfs_pkg::REG_LOOP_ENABLE, {31'd0, l});
    cfg_write(sfs_pkg::REG_FIRST_FRAME, {24'd0, f});
    cfg_write(sfs_pkg::REG_END_FRAME, {23'd0, e});
    cfg_write(sfs_pkg::REG_SPEED, {16'd0, s});
  endtask

  task automatic offer_item(input logic [2:0] f, input logic [15:0] ms, input logic [7:0] fi,
                            input logic [15:0] dur);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    elapsed_ms  <= ms;
    frame_index <= fi;
    duration_ms <= dur;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [15:0] pick_duration();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return 16'd0;
    if (r == 2) return 16'($urandom);
    return 16'($urandom_range(1, 40));
  endfunction

  task automatic offer_random_item();
    int          pick;
    logic [2:0]  f;
    logic [15:0] ms;
    pick = $urandom_range(0, 99);
    if (pick < 45) f = sfs_pkg::FUNC_TICK;
    else if (pick < 60) f = sfs_pkg::FUNC_LOAD;
    else if (pick < 72) f = sfs_pkg::FUNC_SET;
    else if (pick < 80) f = sfs_pkg::FUNC_RESTART;
    else if (pick < 88) f = sfs_pkg::FUNC_CLEAR;
    else if (pick < 93) f = 3'($urandom_range(FUNC_SPARE_A, FUNC_SPARE_C));
    else f = sfs_pkg::FUNC_TICK;
    if ($urandom_range(0, 9) == 0) ms = 16'($urandom);
    else ms = 16'($urandom_range(0, 120));
    offer_item(f, ms, 8'($urandom), pick_duration());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int ph;
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every table entry is written before any tick reads one
    for (n = 0; n < 256; n++)
      offer_item(sfs_pkg::FUNC_LOAD, 16'($urandom), 8'(n), pick_duration());

    // reset settings: single frame range that holds at once
    offer_item(sfs_pkg::FUNC_TICK, 16'd0, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_LOAD, 16'd0, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_TICK, 16'd5, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_SET, 16'd0, 8'd255, 16'd0);
    offer_item(sfs_pkg::FUNC_TICK, 16'hFFFF, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_LOAD, 16'd0, 8'd255, 16'hFFFF);
    offer_item(sfs_pkg::FUNC_SET, 16'd0, 8'd255, 16'd0);
    offer_item(sfs_pkg::FUNC_TICK, 16'hFFFF, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_TICK, 16'd1, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_CLEAR, 16'hFFFF, 8'd255, 16'hFFFF);
    offer_item(sfs_pkg::FUNC_RESTART, 16'hFFFF, 8'd255, 16'hFFFF);
    offer_item(FUNC_SPARE_A, 16'hFFFF, 8'd255, 16'hFFFF);
    offer_item(FUNC_SPARE_B, 16'hFFFF, 8'd255, 16'hFFFF);
    offer_item(FUNC_SPARE_C, 16'hFFFF, 8'd255, 16'hFFFF);
    wait_idle();

    // full range looping at top speed, accumulator saturation
    apply_setting(1'b1, 8'd0, 9'd256, 16'hFFFF);
    offer_item(sfs_pkg::FUNC_SET, 16'd0, 8'd255, 16'd0);
    offer_item(sfs_pkg::FUNC_TICK, 16'hFFFF, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_TICK, 16'hFFFF, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_TICK, 16'd0, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_LOAD, 16'd0, 8'd128, 16'd0);
    offer_item(sfs_pkg::FUNC_RESTART, 16'd0, 8'd0, 16'd0);
    offer_item(sfs_pkg::FUNC_TICK, 16'd7, 8'd0, 16'd0);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_setting(1'b1, 8'd0, 9'd256, 16'd256);
        1: apply_setting(1'b0, 8'd10, 9'd20, 16'hFFFF);
        2: apply_setting(1'b1, 8'd255, 9'd256, 16'd1);
        3: apply_setting(1'b0, 8'd200, 9'd50, 16'd4096);
        4: apply_setting(1'b1, 8'd3, 9'd7, 16'd0);
        5: apply_setting(1'b0, 8'd0, 9'd1, 16'd300);
        6: apply_setting(1'b1, 8'd100, 9'd101, 16'd512);
        default: apply_setting(1'($urandom_range(0, 1)), 8'($urandom),
                               9'($urandom_range(1, 256)), 16'($urandom));
      endcase
      if (ph < 3) begin
        tx_idle_pct = 23;
        rx_idle_pct = 45;
      end else if (ph < 6) begin
        tx_idle_pct = 45;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 1) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) offer_random_item();
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && in_flight == 0) begin
      $display("sprite_frame_sequencer_unit: match");
    end else begin
      $display("sprite_frame_sequencer_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sprite_frame_sequencer_unit.f
design/sfs_pkg.sv
design/sfs_ram.sv
design/sfs_rem.sv
design/sprite_frame_sequencer_unit.sv
verif/frame_sequence_checker.sv
verif/tb_top.sv
